/* rtl/core/bba_pkg.sv */
// Shared types and constants of the bitmap block allocator.
// Used by bba_ctrl, bba_dp, bitmap_block_allocator, bba_checker and tb; depends on nothing.
`default_nettype none

package bba_pkg;

    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;

    localparam int OP_W  = 1;
    localparam int IDX_W = 12;
    localparam int CFG_W = 13;
    localparam int BNO_W = 12;
    localparam int ST_W  = 2;

    localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RST = 13'd4096;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2
    } st_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic cap;           // latch the input transaction
        logic clr_wr;        // clear one map word, advance the pointer
        logic scan_start;    // read word 0, rewind the scan
        logic scan_next;     // read the next word, advance the scan
        logic alloc_commit;  // set the found bit, load an ok result
        logic nospace;       // load a no-space result
        logic free_prep;     // find the word that holds the index, check range
        logic free_read;     // read the word holding the freed bit, latch the bit position
        logic free_commit;   // clear the bit, load an ok result
        logic range_err;     // load an out-of-range result
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op_free;
        logic scan_hit;
        logic scan_end;
        logic range_err;
        logic clr_last;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/core/bba_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Holds the free map; no dependencies.
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bba_ctrl.sv */
// Controller state machine of the bitmap block allocator.
// Sequences clearing, scanning and freeing; uses bba_pkg command and status types.
`default_nettype none

module bba_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output bba_pkg::cmd_t      cmd,
    input  wire bba_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   load;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                // hold until the output register is free for this result
                if (!out_valid_reg || out_ready)
                begin
                    if (sts.op_free)
                    begin
                        cmd.free_prep = 1'b1;
                        state_next    = S_FREE_RD;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                priority if (sts.scan_hit)
                begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = S_IDLE;
                end
                else if (sts.scan_end)
                begin
                    cmd.nospace = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_FREE_RD:
            begin
                if (sts.range_err)
                begin
                    cmd.range_err = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.free_read = 1'b1;
                    state_next    = S_FREE_WR;
                end
            end
            S_FREE_WR:
            begin
                cmd.free_commit = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign load = cmd.alloc_commit | cmd.nospace | cmd.range_err | cmd.free_commit;

    always_comb
    begin
        priority if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A new result never lands on one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || out_ready))
        else $error("result loaded while output register busy");

    // At most one datapath action that moves the map or the result per cycle
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.alloc_commit, cmd.nospace, cmd.range_err, cmd.free_commit,
                  cmd.scan_next, cmd.scan_start, cmd.free_read, cmd.clr_wr}))
        else $error("conflicting datapath commands");

    // A bit is cleared only right after its word was read
    a_free_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.free_commit |-> $past(cmd.free_read))
        else $error("free commit without preceding read");

    // An accepted transaction moves straight on to its start step
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_START))
        else $error("accepted transaction not started");

endmodule

`default_nettype wire

/* rtl/core/bba_dp.sv */
// Datapath of the bitmap block allocator: free map RAM, scan pointers,
// first-clear-bit search, index split and result registers. Uses bba_pkg and bba_ram.
`default_nettype none

module bba_dp #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire bba_pkg::cmd_t             cmd,
    output bba_pkg::sts_t                  sts,
    input  wire logic [bba_pkg::OP_W-1:0]  in_op,
    input  wire logic [bba_pkg::IDX_W-1:0] in_idx,
    input  wire logic                      cfg_we,
    input  wire logic [bba_pkg::CFG_W-1:0] cfg_data,
    output logic      [bba_pkg::BNO_W-1:0] block_number,
    output logic      [bba_pkg::ST_W-1:0]  status
);

    localparam int IDX_W     = bba_pkg::IDX_W;
    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int RS_W      = BIT_W + 1;
    localparam int NUM_RAW   = $clog2((MAP_WORDS + 1) * WORD_BITS + 1);
    localparam int NUM_W     = (NUM_RAW > bba_pkg::CFG_W) ? NUM_RAW : bba_pkg::CFG_W;
    // index / WORD_BITS as a multiply by a rounded-up reciprocal, exact for IDX_W bits
    localparam int RSH       = IDX_W + BIT_W;
    localparam int RECIP     = ((2 ** RSH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W    = 2 * IDX_W + 1;

    logic [bba_pkg::CFG_W-1:0] total_blocks_reg;
    logic [bba_pkg::OP_W-1:0]  op_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          q_reg;
    logic                      range_reg;
    logic [BIT_W-1:0]          bit_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic [ADDR_W-1:0]         exam_reg;
    logic [NUM_W-1:0]          base_reg;
    logic [bba_pkg::BNO_W-1:0] bno_reg;
    logic [bba_pkg::ST_W-1:0]  status_reg;

    logic [NUM_W-1:0]     limit, tb_ext, diff, base_plus, hit_num;
    logic [RS_W-1:0]      rem_sat;
    logic [WORD_BITS-1:0] valid_mask, free_bits, rdata, wdata;
    logic [BIT_W-1:0]     hit_bit;
    logic                 hit;
    logic [PROD_W-1:0]    prod, prod_sh;
    logic [IDX_W-1:0]     q_calc, idx_rem;
    logic [ADDR_W-1:0]    q_word, waddr, raddr;
    logic                 we, re;

    // Effective limit: configured count saturated at the map size
    assign tb_ext = NUM_W'(total_blocks_reg);
    assign limit  = (tb_ext > NUM_W'(MAX_BLOCKS)) ? NUM_W'(MAX_BLOCKS) : tb_ext;

    // Number of usable bits in the word under examination
    assign diff      = limit - base_reg;
    assign base_plus = base_reg + NUM_W'(WORD_BITS);
    always_comb
    begin
        priority if (base_reg >= limit)
        begin
            rem_sat = '0;
        end
        else if (diff >= NUM_W'(WORD_BITS))
        begin
            rem_sat = RS_W'(WORD_BITS);
        end
        else
        begin
            rem_sat = diff[RS_W-1:0];
        end
    end

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            valid_mask[b] = (RS_W'(b) < rem_sat);
        end
    end

    assign free_bits = ~rdata & valid_mask;
    assign hit       = |free_bits;

    // Lowest clear bit wins
    always_comb
    begin
        hit_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                hit_bit = BIT_W'(b);
            end
        end
    end

    assign hit_num = base_reg + NUM_W'(hit_bit);

    // Index split for a free
    assign prod    = PROD_W'(idx_reg) * PROD_W'(RECIP);
    assign prod_sh = prod >> RSH;
    assign q_calc  = prod_sh[IDX_W-1:0];
    assign idx_rem = idx_reg - IDX_W'(q_reg * WORD_BITS);
    assign q_word  = ADDR_W'(q_reg);

    // Map RAM port control
    always_comb
    begin
        we    = 1'b0;
        waddr = addr_reg;
        wdata = '0;
        re    = 1'b0;
        raddr = addr_reg;
        priority if (cmd.clr_wr)
        begin
            we = 1'b1;
        end
        else if (cmd.scan_start)
        begin
            re    = 1'b1;
            raddr = '0;
        end
        else if (cmd.scan_next)
        begin
            re = 1'b1;
        end
        else if (cmd.alloc_commit)
        begin
            we    = 1'b1;
            waddr = exam_reg;
            wdata = rdata | (WORD_BITS'(1) << hit_bit);
        end
        else if (cmd.free_read)
        begin
            re    = 1'b1;
            raddr = q_word;
        end
        else if (cmd.free_commit)
        begin
            we    = 1'b1;
            waddr = q_word;
            wdata = rdata & ~(WORD_BITS'(1) << bit_reg);
        end
        else
        begin
            we = 1'b0;
        end
    end

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (ADDR_W)
    ) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Control registers: config and scan pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_blocks_reg <= bba_pkg::TOTAL_BLOCKS_RST;
            addr_reg         <= '0;
            exam_reg         <= '0;
            base_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                total_blocks_reg <= cfg_data;
            end
            priority if (cmd.clr_wr)
            begin
                addr_reg <= addr_reg + ADDR_W'(1);
            end
            else if (cmd.scan_start)
            begin
                addr_reg <= ADDR_W'(1);
                exam_reg <= '0;
                base_reg <= '0;
            end
            else if (cmd.scan_next)
            begin
                addr_reg <= addr_reg + ADDR_W'(1);
                exam_reg <= addr_reg;
                base_reg <= base_plus;
            end
            else
            begin
                addr_reg <= addr_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            op_reg  <= in_op;
            idx_reg <= in_idx;
        end
        if (cmd.free_prep)
        begin
            q_reg     <= q_calc;
            range_reg <= (NUM_W'(idx_reg) >= limit);
        end
        if (cmd.free_read)
        begin
            bit_reg <= idx_rem[BIT_W-1:0];
        end
        priority if (cmd.alloc_commit)
        begin
            bno_reg    <= hit_num[bba_pkg::BNO_W-1:0];
            status_reg <= bba_pkg::ST_OK;
        end
        else if (cmd.nospace)
        begin
            bno_reg    <= '0;
            status_reg <= bba_pkg::ST_NOSPACE;
        end
        else if (cmd.range_err)
        begin
            bno_reg    <= '0;
            status_reg <= bba_pkg::ST_RANGE;
        end
        else if (cmd.free_commit)
        begin
            bno_reg    <= '0;
            status_reg <= bba_pkg::ST_OK;
        end
        else
        begin
            bno_reg <= bno_reg;
        end
    end

    always_comb
    begin
        sts           = '0;
        sts.op_free   = (op_reg == bba_pkg::OP_FREE);
        sts.scan_hit  = hit;
        sts.scan_end  = (base_plus >= limit) || (exam_reg == ADDR_W'(MAP_WORDS - 1));
        sts.range_err = range_reg;
        sts.clr_last  = (addr_reg == ADDR_W'(MAP_WORDS - 1));
    end

    assign block_number = bno_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

/* rtl/core/bitmap_block_allocator.sv */
// Bitmap block allocator: first-fit allocate and free over a one-bit-per-block map.
// Top level; instantiates bba_ctrl and bba_dp, uses bba_pkg.
//
// Input stream (s_*): s_tuser is the operation (0 allocate, 1 free), s_tdata[11:0]
// the block index to free. Output stream (m_*): m_tdata[11:0] the allocated block
// number (zero otherwise), m_tuser the status (0 ok, 1 no space, 2 out of range).
// Every input transaction gives exactly one output transaction, in order.
// cfg_* writes the block count; write it only while no transaction is in flight.
//
// Allocate loads its result once the scan finds a clear bit or ends; it scans 1 to
// MAP_WORDS map words (128 by default) and reads one map word per cycle through the
// single read port of the map RAM. Free loads its result after index split with range
// check, read and write back, or after the range check when the index is out of range.
// s_tready returns in the cycle after a result is loaded, so one transaction is in work
// at a time. The next transaction is accepted while a result waits in the output
// register; its processing holds until that result is taken, so a stalled receiver
// stalls the block. After reset the map is cleared one word per cycle, all MAP_WORDS
// words (128 by default), with s_tready low; the block count returns to 4096.
`default_nettype none

module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [11:0] block_index, [15:12] zero
    input  wire logic [0:0]  s_tuser,   // [0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [11:0] block_number, [15:12] zero
    output logic      [1:0]  m_tuser,   // [1:0] status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] cfg_data   // [12:0] total_blocks
);

    bba_pkg::cmd_t             cmd;
    bba_pkg::sts_t             sts;
    logic [bba_pkg::BNO_W-1:0] block_number;
    logic [bba_pkg::ST_W-1:0]  status;

    assign cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BITS  (WORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_op        (s_tuser),
        .in_idx       (s_tdata[bba_pkg::IDX_W-1:0]),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_data     (cfg_data),
        .block_number (block_number),
        .status       (status)
    );

    assign m_tdata = {4'b0000, block_number};
    assign m_tuser = status;

endmodule

`default_nettype wire

/* sim/bba_checker.sv */
// Checker for the bitmap block allocator: watches the request, result and block count
// channels, predicts each result with its own first-fit map and compares in order.
// Depends on bba_pkg for field widths, operation and status codes.
module bba_checker
    import bba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [15:0]       s_tdata,
    input  wire logic [0:0]        s_tuser,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [15:0]       m_tdata,
    input  wire logic [1:0]        m_tuser,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_SIZE = MAX_BLOCKS_DEF;

    typedef struct packed {
        logic [BNO_W-1:0] bno;
        st_t              st;
    } grant_t;

    bit               used [MAP_SIZE];
    logic [CFG_W-1:0] blk_count;
    grant_t           grants_due [$];

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic int unsigned usable_blocks();
        return (blk_count > MAP_SIZE) ? MAP_SIZE : blk_count;
    endfunction

    // First fit: lowest clear bit below the usable count
    function automatic grant_t serve_request(op_t op, logic [IDX_W-1:0] idx);
        grant_t      g;
        int unsigned lim;
        int          n;
        lim   = usable_blocks();
        g.bno = '0;
        if (op == OP_ALLOC)
        begin
            g.st = ST_NOSPACE;
            for (n = 0; n < lim; n++)
            begin
                if (!used[n])
                begin
                    used[n] = 1'b1;
                    g.bno   = n[BNO_W-1:0];
                    g.st    = ST_OK;
                    break;
                end
            end
        end
        else if (idx >= lim)
        begin
            g.st = ST_RANGE;
        end
        else
        begin
            used[idx] = 1'b0;
            g.st      = ST_OK;
        end
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        if (!rst_n)
        begin
            foreach (used[i])
                used[i] = 1'b0;
            blk_count = TOTAL_BLOCKS_RST;
            grants_due.delete();
            fail_count = 0;
            in_flight <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                blk_count = cfg_data;
            if (s_tvalid && s_tready)
                grants_due.push_back(serve_request(op_t'(s_tuser), s_tdata[IDX_W-1:0]));
            if (m_tvalid && m_tready)
            begin
                if (grants_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result, block %0d status %0d",
                                              m_tdata, m_tuser));
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (m_tdata[BNO_W-1:0] !== want.bno || m_tdata[15:BNO_W] !== '0)
                        report_mismatch($sformatf("block number %0d, expected %0d",
                                                  m_tdata, want.bno));
                    if (m_tuser !== want.st)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tuser, want.st));
                end
            end
            in_flight <= grants_due.size();
        end
    end

endmodule

/* sim/tb.sv */
// Top of the bitmap block allocator testbench: clock, reset, directed and random requests,
// block count changes between phases, receiver stalls, watchdog and the verdict.
// Depends on bba_pkg, bitmap_block_allocator and bba_checker.
module tb;
    import bba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata   = '0;
    logic [0:0]       s_tuser   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [15:0]      m_tdata;
    logic [1:0]       m_tuser;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    int fail_count;
    int in_flight;
    int quiet_cycles = 0;
    int gap_pct      = 0;
    int stall_pct    = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bitmap_block_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bba_checker i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .in_flight  (in_flight)
    );

    // Receiver: drop tready for a random burst now and then
    always
    begin
        @(posedge clk);
        if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_request(op_t op, logic [IDX_W-1:0] idx);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, idx};
        do @(posedge clk); while (s_tready !== 1'b1);
    endtask

    // Hold off until every expected result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
    endtask

    task automatic write_block_count(logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [CFG_W-1:0] count, int items, int alloc_pct,
                             int gap, int stall);
        int unsigned      lim;
        int unsigned      pick;
        logic [IDX_W-1:0] idx;
        int               k;
        drain();
        write_block_count(count);
        gap_pct   = gap;
        stall_pct = stall;
        lim = (count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : count;
        for (k = 0; k < items; k++)
        begin
            pick = $urandom_range(0, 99);
            idx  = IDX_W'($urandom);
            if (pick < alloc_pct)
                send_request(OP_ALLOC, idx);
            else if (pick < 86 && lim != 0)
                send_request(OP_FREE, IDX_W'($urandom_range(0, lim - 1)));
            else if (pick < 92)
                // straddle the range boundary
                send_request(OP_FREE, IDX_W'(lim - $urandom_range(0, 1)));
            else
                send_request(OP_FREE, idx);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset block count: simple allocate and free, both index extremes
        send_request(OP_ALLOC, 12'd0);
        send_request(OP_ALLOC, 12'd0);
        send_request(OP_ALLOC, 12'd0);
        send_request(OP_FREE, 12'd1);
        send_request(OP_ALLOC, 12'd0);
        send_request(OP_FREE, 12'd4095);
        send_request(OP_FREE, 12'd0);
        send_request(OP_ALLOC, 12'd0);
        send_request(OP_ALLOC, 12'd4095);
        // Zero blocks: no space on allocate, range error on free
        drain();
        write_block_count(13'd0);
        send_request(OP_ALLOC, 12'd0);
        send_request(OP_FREE, 12'd0);
        // Count above the map size saturates
        drain();
        write_block_count(13'd8191);
        send_request(OP_FREE, 12'd4095);
        send_request(OP_ALLOC, 12'd0);
        // Allocate on a small device that is already full, free at and below the limit
        drain();
        write_block_count(13'd5);
        send_request(OP_ALLOC, 12'd0);
        send_request(OP_ALLOC, 12'd0);
        send_request(OP_FREE, 12'd5);
        send_request(OP_FREE, 12'd4);
        // Count lowered below allocated blocks
        drain();
        write_block_count(13'd2);
        send_request(OP_FREE, 12'd3);
        send_request(OP_ALLOC, 12'd0);
        send_request(OP_FREE, 12'd1);
        send_request(OP_ALLOC, 12'd0);

        run_phase(13'd1,    40,  50, 10, 10);
        run_phase(13'd33,   150, 65, 20, 20);
        run_phase(13'd0,    30,  50, 0,  0);
        run_phase(13'd8191, 200, 70, 15, 30);
        run_phase(13'd32,   150, 60, 30, 10);
        run_phase(13'd100,  200, 60, 0,  25);
        run_phase(13'd64,   150, 55, 25, 0);
        run_phase(13'd4095, 150, 75, 10, 10);
        run_phase(13'd7,    120, 50, 20, 20);
        run_phase(13'd4096, 240, 60, 0,  0);

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* bitmap_block_allocator.f */
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_dp.sv
rtl/core/bitmap_block_allocator.sv
sim/bba_checker.sv
sim/tb.sv
